// ===== design/tmcw_pkg.sv =====
package tmcw_pkg;

    // Request kinds carried in req_type
    localparam logic [1:0] REQ_PRINT      = 2'd0;
    localparam logic [1:0] REQ_SET_CURSOR = 2'd1;
    localparam logic [1:0] REQ_CLEAR      = 2'd2;
    localparam logic [1:0] REQ_READ       = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] REG_FG_COLOR = 8'd0;
    localparam logic [7:0] REG_BG_COLOR = 8'd1;

    // Control characters and glyphs
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_BAR     = 8'h7c;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Address width of the largest supported screen (256 x 64 cells)
    localparam int CELL_ADDR_W = 14;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [7:0] target_col;
        logic [7:0] target_row;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_item_t;

    // One write port and one read port of the screen memory
    typedef struct packed {
        logic                   wr_en;
        logic [CELL_ADDR_W-1:0] wr_addr;
        logic [15:0]            wr_data;
        logic                   rd_en;
        logic [CELL_ADDR_W-1:0] rd_addr;
    } ram_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCROLL,
        ST_CLEAR,
        ST_READ_WAIT,
        ST_DONE
    } seq_state_t;

endpackage

// ===== design/tmcw_screen_ram.sv =====
module tmcw_screen_ram #(
    parameter int DEPTH = 2000
) (
    input  logic                aclk,
    input  tmcw_pkg::ram_cmd_t  cmd,
    output logic [15:0]         rd_data
);
    import tmcw_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [15:0] mem [DEPTH];

    // Cell storage: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data <= mem[cmd.rd_addr[AW-1:0]];
        end
    end

endmodule

// ===== design/tmcw_sequencer.sv =====
module tmcw_sequencer #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int TAB_STEP    = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tmcw_pkg::in_item_t  s_data,
    input  logic [7:0]          attr,
    input  logic                out_free,
    output logic                res_load,
    output tmcw_pkg::out_item_t res,
    output tmcw_pkg::ram_cmd_t  ram_cmd,
    input  logic [15:0]         ram_rdata
);
    import tmcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
    localparam int COPY_N     = SCREEN_COLS * (SCREEN_ROWS - 1);
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(SCREEN_COLS + 1);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int SUM_W      = $clog2(SCREEN_COLS + TAB_STEP + 1);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);
    localparam logic [COL_W-1:0] COLS_C   = COL_W'(SCREEN_COLS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [CNT_W-1:0] CNT_COPY = CNT_W'(COPY_N);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CELL_COUNT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_COLS = CNT_W'(SCREEN_COLS);
    localparam logic [SUM_W-1:0] SUM_COLS = SUM_W'(SCREEN_COLS);
    localparam logic [SUM_W-1:0] SUM_TAB  = SUM_W'(TAB_STEP);
    localparam logic [AW-1:0]    AW_COLS  = AW'(SCREEN_COLS);

    seq_state_t       state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             resume_reg, resume_next;
    logic [1:0]       req_reg, req_next;
    logic [7:0]       ch_reg, ch_next;
    logic [COL_W-1:0] tc_reg, tc_next;
    logic [ROW_W-1:0] tr_reg, tr_next;
    logic [15:0]      cell_reg, cell_next;

    logic             is_nl, is_cr, is_tab, wrap_pend, last_row, tab_over;
    logic [SUM_W-1:0] tab_sum;
    logic [ROW_W-1:0] addr_row;
    logic [COL_W-1:0] addr_col;
    logic [AW-1:0]    cell_addr;
    logic [15:0]      blank_cell;
    seq_state_t       finish_st;
    logic [COL_W+6:0] col_ext;
    logic [ROW_W+4:0] row_ext;

    // Decode of the held item and cursor
    always_comb begin
        is_nl     = (ch_reg == CH_NEWLINE);
        is_cr     = (ch_reg == CH_RETURN);
        is_tab    = (ch_reg == CH_TAB);
        wrap_pend = (col_reg >= COLS_C);
        last_row  = (row_reg == LAST_ROW);
        tab_sum   = SUM_W'(col_reg) + SUM_TAB;
        tab_over  = (tab_sum >= SUM_COLS);
        finish_st = out_free ? ST_IDLE : ST_DONE;
        blank_cell = {attr, CH_SPACE};
    end

    // Shared cell address unit: row * cols + col
    always_comb begin
        addr_row  = (req_reg == REQ_READ) ? tr_reg : row_reg;
        addr_col  = (req_reg == REQ_READ) ? tc_reg : col_reg;
        cell_addr = AW'(addr_row) * AW_COLS + AW'(addr_col);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (req_reg)
                    REQ_SET_CURSOR: state_next = finish_st;
                    REQ_CLEAR:      state_next = ST_CLEAR;
                    REQ_READ:       state_next = ST_READ_WAIT;
                    REQ_PRINT: begin
                        if (is_nl) begin
                            state_next = last_row ? ST_SCROLL : finish_st;
                        end else if (is_cr) begin
                            state_next = finish_st;
                        end else if (wrap_pend) begin
                            state_next = last_row ? ST_SCROLL : ST_DECODE;
                        end else if (is_tab && tab_over && last_row) begin
                            state_next = ST_SCROLL;
                        end else begin
                            state_next = finish_st;
                        end
                    end
                endcase
            end
            ST_SCROLL: begin
                if (cnt_reg == CNT_END) begin
                    state_next = resume_reg ? ST_DECODE : ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_WAIT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory commands and result
    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        resume_next = resume_reg;
        req_next    = req_reg;
        ch_next     = ch_reg;
        tc_next     = tc_reg;
        tr_next     = tr_reg;
        cell_next   = cell_reg;
        s_ready     = 1'b0;
        ram_cmd     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next  = s_data.req_type;
                    ch_next   = s_data.char_code;
                    tc_next   = (s_data.target_col > 8'(SCREEN_COLS - 1)) ?
                                LAST_COL : COL_W'(s_data.target_col);
                    tr_next   = (s_data.target_row > 8'(SCREEN_ROWS - 1)) ?
                                LAST_ROW : ROW_W'(s_data.target_row);
                    cell_next = '0;
                end
            end
            ST_DECODE: begin
                unique case (req_reg)
                    REQ_SET_CURSOR: begin
                        col_next = tc_reg;
                        row_next = tr_reg;
                    end
                    REQ_CLEAR: cnt_next = '0;
                    REQ_READ: begin
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = CELL_ADDR_W'(cell_addr);
                    end
                    REQ_PRINT: begin
                        if (is_nl) begin
                            if (last_row) begin
                                cnt_next    = '0;
                                resume_next = 1'b0;
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end else if (is_cr) begin
                            col_next = '0;
                        end else if (wrap_pend) begin
                            // pending wrap: newline first, then revisit this item
                            col_next = '0;
                            if (last_row) begin
                                cnt_next    = '0;
                                resume_next = 1'b1;
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end else begin
                            ram_cmd.wr_en   = 1'b1;
                            ram_cmd.wr_addr = CELL_ADDR_W'(cell_addr);
                            ram_cmd.wr_data = {attr, is_tab ? CH_BAR : ch_reg};
                            if (is_tab) begin
                                if (tab_over) begin
                                    col_next = '0;
                                    if (last_row) begin
                                        cnt_next    = '0;
                                        resume_next = 1'b0;
                                    end else begin
                                        row_next = row_reg + ROW_W'(1);
                                    end
                                end else begin
                                    col_next = COL_W'(tab_sum);
                                end
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    end
                endcase
            end
            ST_SCROLL: begin
                // read cell cnt+cols, write the cell read last cycle one row up
                ram_cmd.rd_en   = (cnt_reg < CNT_COPY);
                ram_cmd.rd_addr = CELL_ADDR_W'(AW'(cnt_reg + CNT_COLS));
                ram_cmd.wr_en   = (cnt_reg != '0);
                ram_cmd.wr_addr = CELL_ADDR_W'(AW'(cnt_reg - CNT_W'(1)));
                ram_cmd.wr_data = (cnt_reg <= CNT_COPY) ? ram_rdata : blank_cell;
                cnt_next        = cnt_reg + CNT_W'(1);
            end
            ST_CLEAR: begin
                ram_cmd.wr_en   = 1'b1;
                ram_cmd.wr_addr = CELL_ADDR_W'(AW'(cnt_reg));
                ram_cmd.wr_data = blank_cell;
                cnt_next        = cnt_reg + CNT_W'(1);
            end
            ST_READ_WAIT: cell_next = ram_rdata;
            ST_DONE: ;
            default: ;
        endcase

        // result goes out whenever work ends this cycle
        res_load       = (state_reg != ST_IDLE) && (state_next == ST_IDLE);
        col_ext        = {7'd0, col_next};
        row_ext        = {5'd0, row_next};
        res.cursor_col = col_ext[6:0];
        res.cursor_row = row_ext[4:0];
        res.cell_char  = cell_next[7:0];
        res.cell_attr  = cell_next[15:8];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Item and sweep registers
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        resume_reg <= resume_next;
        req_reg    <= req_next;
        ch_reg     <= ch_next;
        tc_reg     <= tc_next;
        tr_reg     <= tr_next;
        cell_reg   <= cell_next;
    end

endmodule

// ===== design/text_mode_console_writer_unit.sv =====
// Text-mode console writer: a screen of character/attribute cells and a cursor.
// Input channel s_*: one request item (print, set cursor, clear, read cell).
// Result channel m_*: one item per request with the cursor after the request
// and, for a read, the addressed cell (zero otherwise).
// Config channel cfg_*: register 0 foreground color, 1 background color;
// always ready; the user must write it only while the block is idle (not enforced).
// Steps from input accept to result, set by the step sequencer and the
// single-port-write screen memory:
//   set cursor, return, newline without scroll, tab or byte: decode step
//   byte/tab on a pending wrap: wrap, then as above; read cell: decode, read, done
//   clear screen: decode, then all COLS*ROWS cells (one cell per cycle), done
//   scroll (newline on the last row): screen moves up a row, one cell per cycle
// One item is in work at a time; s_ready is high only between items.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds back only the finish of that next item.
// Reset clears the cursor and sets colors (fg 15, bg 0); screen cells are undefined
// until written by a print, a clear or a scroll.
module text_mode_console_writer_unit #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int TAB_STEP    = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tmcw_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tmcw_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import tmcw_pkg::*;

    logic [3:0]  fg_reg, bg_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    logic        out_free;
    logic        res_load;
    out_item_t   res;
    ram_cmd_t    ram_cmd;
    logic [15:0] ram_rdata;

    // Color registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= 4'hf;
            bg_reg <= 4'h0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FG_COLOR: fg_reg <= cfg_data[3:0];
                REG_BG_COLOR: bg_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    tmcw_sequencer #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS),
        .TAB_STEP   (TAB_STEP)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .attr     ({bg_reg, fg_reg}),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res),
        .ram_cmd  (ram_cmd),
        .ram_rdata(ram_rdata)
    );

    tmcw_screen_ram #(
        .DEPTH(SCREEN_COLS * SCREEN_ROWS)
    ) u_ram (
        .aclk   (aclk),
        .cmd    (ram_cmd),
        .rd_data(ram_rdata)
    );

    // Output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> out_free)
        else $error("result loaded over a pending item");

    // An accepted item closes the input in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    // No result is produced while waiting for an item
    a_no_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_load)
        else $error("result produced with no item in work");

    // Every accepted item ends in a result before the next accept
    a_result_per_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready ##1 s_ready |-> $past(res_load))
        else $error("item finished without a result");

endmodule
